FILE: design/cdg_pkg.sv
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared widths, register indexes, sideband types and rounding helper for the
// cylinder distance and gradient pipeline.
// ----------------------------------------------------------------------------
package cdg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int QBITS      = FRAC_BITS + 1;   // gradient quotient bits
    localparam int GRAD_ONE   = 1 << FRAC_BITS;
    localparam int GW         = 18;              // gradient field width
    localparam int GRAD_MAX   = (1 << (GW - 1)) - 1;
    localparam int DW         = 32;              // distance / coordinate width
    localparam int U_SHIFT    = 29;              // unit axis has length 2^29
    localparam int UW         = 31;              // signed unit axis component
    localparam int PW         = 33;              // point minus center
    localparam int PRODW      = PW + UW;
    localparam int DOTW       = PRODW + 2;
    localparam int TW         = 36;              // axial coordinate
    localparam int TUW        = TW + UW;
    localparam int RW         = 70;              // rounding helper width
    localparam int VW         = 36;              // perpendicular component
    localparam int SW         = 31;              // scaled magnitude
    localparam int KW         = 3;               // scale shift
    localparam int SQW        = 64;
    localparam int SQRT_STEPS = 32;
    localparam int LW         = 33;              // rounded length
    localparam int CIW        = 3;               // config index width

    localparam logic [CIW-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CIW-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CIW-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CIW-1:0] REG_RADIUS   = 3'd3;
    localparam logic [CIW-1:0] REG_AXIS_X   = 3'd4;
    localparam logic [CIW-1:0] REG_AXIS_Y   = 3'd5;
    localparam logic [CIW-1:0] REG_AXIS_Z   = 3'd6;

    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][SW-1:0]  mag;
        logic [KW-1:0]       k;
    } sqrt_side_t;

    typedef struct packed {
        logic signed [DW-1:0] sdist;
        logic                 on_axis;
        logic [2:0]           neg;
    } grad_side_t;

    // x / 2^29, round to nearest, halves away from zero
    function automatic logic signed [RW-1:0] rnd_sh29(input logic signed [RW-1:0] x);
        logic [RW-1:0] mag;
        logic [RW-1:0] r;
        mag = x[RW-1] ? $unsigned(-x) : $unsigned(x);
        r   = (mag + (RW'(1) << (U_SHIFT - 1))) >> U_SHIFT;
        return x[RW-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

FILE: design/cdg_axis_norm.sv
// ----------------------------------------------------------------------------
// cdg_axis_norm
// Sequential axis normalizer: leading shift, sum of squares, bitwise square
// root and three long divisions produce the 2^29-scaled unit axis.
// ----------------------------------------------------------------------------
module cdg_axis_norm import cdg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [31:0]   axis [3],
    output logic signed [UW-1:0] u [3],
    output logic                 busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_NORM = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DSET = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [31:0]         am_reg [3];
    logic [31:0]         am_next [3];
    logic [2:0]          neg_reg, neg_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [1:0]          comp_reg, comp_next;
    logic [63:0]         x_reg, x_next;
    logic [63:0]         res_reg, res_next;
    logic [31:0]         lsq_reg, lsq_next;
    logic [31:0]         rem_reg, rem_next;
    logic [30:0]         nlo_reg, nlo_next;
    logic [30:0]         q_reg, q_next;
    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] u_next [3];

    logic [63:0] bitv;
    logic [64:0] strial;
    logic [60:0] num;
    logic [32:0] dtrial;
    logic        ge;

    always_comb begin
        state_next = state_reg;
        am_next    = am_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        lsq_next   = lsq_reg;
        rem_next   = rem_reg;
        nlo_next   = nlo_reg;
        q_next     = q_reg;
        u_next     = u_reg;
        bitv       = 64'd1 << (6'd62 - {cnt_reg, 1'b0});
        strial     = {1'b0, res_reg} + {1'b0, bitv};
        num        = {am_reg[comp_reg][31:0], 29'd0} + 61'(lsq_reg >> 1);
        dtrial     = {rem_reg, nlo_reg[30]};
        ge         = dtrial >= {1'b0, lsq_reg};
        case (state_reg)
            ST_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    am_next[i]  = axis[i][31] ? $unsigned(-axis[i]) : $unsigned(axis[i]);
                    neg_next[i] = axis[i][31];
                end
                if (axis[0] == '0 && axis[1] == '0 && axis[2] == '0) begin
                    // degenerate axis falls back to +z
                    u_next[0]  = '0;
                    u_next[1]  = '0;
                    u_next[2]  = UW'(1 << U_SHIFT);
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if ((am_reg[0][31:30] | am_reg[1][31:30] | am_reg[2][31:30]) != 2'b00) begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                    x_next     = '0;
                end else begin
                    for (int i = 0; i < 3; i++) am_next[i] = am_reg[i] << 1;
                end
            end
            ST_SQ: begin
                x_next = x_reg + 64'(am_reg[cnt_reg[1:0]]) * 64'(am_reg[cnt_reg[1:0]]);
                if (cnt_reg == 5'd2) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                    res_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_SQRT: begin
                if ({1'b0, x_reg} >= strial) begin
                    x_next   = x_reg - strial[63:0];
                    res_next = (res_reg >> 1) + bitv;
                end else begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    lsq_next   = res_next[31:0];
                    comp_next  = '0;
                    state_next = ST_DSET;
                end
            end
            ST_DSET: begin
                rem_next   = 32'(num[60:31]);
                nlo_next   = num[30:0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = ge ? 32'(dtrial - {1'b0, lsq_reg}) : dtrial[31:0];
                nlo_next = nlo_reg << 1;
                q_next   = {q_reg[29:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    u_next[comp_reg] = neg_reg[comp_reg] ? UW'(-$signed({1'b0, q_next}))
                                                         : UW'($signed({1'b0, q_next}));
                    if (comp_reg == 2'd2) begin
                        state_next = ST_IDLE;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_DSET;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (start) state_next = ST_LOAD;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            u_reg[0]  <= '0;
            u_reg[1]  <= '0;
            u_reg[2]  <= UW'(1 << U_SHIFT);
        end else begin
            state_reg <= state_next;
            u_reg     <= u_next;
        end
    end

    always_ff @(posedge aclk) begin
        am_reg   <= am_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        lsq_reg  <= lsq_next;
        rem_reg  <= rem_next;
        nlo_reg  <= nlo_next;
        q_reg    <= q_next;
    end

    assign u    = u_reg;
    assign busy = state_reg != ST_IDLE;

endmodule

FILE: design/cdg_project.sv
// ----------------------------------------------------------------------------
// cdg_project
// Nine-stage front end: offset, axial projection, perpendicular vector,
// range scaling and sum of squares.
// ----------------------------------------------------------------------------
module cdg_project import cdg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] p [3],
    input  logic signed [DW-1:0] c [3],
    input  logic signed [UW-1:0] u [3],
    output logic                 out_valid,
    output logic [SQW-1:0]       sq,
    output sqrt_side_t           side
);

    logic [8:0]              vld_reg;
    logic signed [PW-1:0]    pa1_reg [3];
    logic signed [PW-1:0]    pa2_reg [3];
    logic signed [PW-1:0]    pa3_reg [3];
    logic signed [PW-1:0]    pa4_reg [3];
    logic signed [PW-1:0]    pa5_reg [3];
    logic signed [PRODW-1:0] prod2_reg [3];
    logic signed [DOTW-1:0]  dot3_reg;
    logic signed [TW-1:0]    t4_reg;
    logic signed [TUW-1:0]   tu5_reg [3];
    logic signed [VW-1:0]    v6_reg [3];
    sqrt_side_t              side7_reg, side8_reg, side9_reg;
    logic [61:0]             sqm8_reg [3];
    logic [SQW-1:0]          sq9_reg;

    logic [VW-1:0] vmag [3];
    logic [VW-1:0] vmax;
    logic [KW-1:0] k;

    always_comb begin
        for (int i = 0; i < 3; i++)
            vmag[i] = v6_reg[i][VW-1] ? $unsigned(-v6_reg[i]) : $unsigned(v6_reg[i]);
        vmax = vmag[0];
        if (vmag[1] > vmax) vmax = vmag[1];
        if (vmag[2] > vmax) vmax = vmag[2];
        // smallest shift that brings the largest magnitude below 2^31
        k = '0;
        for (int j = 0; j < VW - 31; j++)
            if (vmax[31 + j]) k = KW'(j + 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[7:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                pa1_reg[i]   <= PW'(p[i]) - PW'(c[i]);
                prod2_reg[i] <= PRODW'(pa1_reg[i]) * PRODW'(u[i]);
                tu5_reg[i]   <= TUW'(t4_reg) * TUW'(u[i]);
                v6_reg[i]    <= VW'(pa5_reg[i]) - VW'(rnd_sh29(RW'(tu5_reg[i])));
                side7_reg.neg[i] <= v6_reg[i][VW-1];
                side7_reg.mag[i] <= SW'(vmag[i] >> k);
            end
            pa2_reg  <= pa1_reg;
            pa3_reg  <= pa2_reg;
            pa4_reg  <= pa3_reg;
            pa5_reg  <= pa4_reg;
            dot3_reg <= DOTW'(prod2_reg[0]) + DOTW'(prod2_reg[1]) + DOTW'(prod2_reg[2]);
            t4_reg   <= TW'(rnd_sh29(RW'(dot3_reg)));
            side7_reg.k <= k;
            for (int i = 0; i < 3; i++)
                sqm8_reg[i] <= 62'(side7_reg.mag[i]) * 62'(side7_reg.mag[i]);
            side8_reg <= side7_reg;
            sq9_reg   <= SQW'(sqm8_reg[0]) + SQW'(sqm8_reg[1]) + SQW'(sqm8_reg[2]);
            side9_reg <= side8_reg;
        end
    end

    assign out_valid = vld_reg[8];
    assign sq        = sq9_reg;
    assign side      = side9_reg;

endmodule

FILE: design/cdg_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// cdg_sqrt_pipe
// Pipelined 64-bit integer square root, one result bit per stage, followed
// by a round-to-nearest stage using the final remainder.
// ----------------------------------------------------------------------------
module cdg_sqrt_pipe import cdg_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [SQW-1:0] sq,
    input  sqrt_side_t     in_side,
    output logic           out_valid,
    output logic [LW-1:0]  len,
    output sqrt_side_t     out_side
);

    logic [SQRT_STEPS:0]  vld_reg;
    logic [SQW-1:0]       x_reg [SQRT_STEPS];
    logic [SQW-1:0]       res_reg [SQRT_STEPS];
    sqrt_side_t           side_reg [SQRT_STEPS];
    logic [SQW-1:0]       x_in [SQRT_STEPS];
    logic [SQW-1:0]       res_in [SQRT_STEPS];
    sqrt_side_t           side_in [SQRT_STEPS];
    logic [LW-1:0]        len_reg;
    sqrt_side_t           side_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[SQRT_STEPS-1:0], in_valid};
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [SQW-1:0] BITV = SQW'(1) << (62 - 2 * j);
        logic [SQW:0] trial;

        if (j == 0) begin : g_first
            assign x_in[j]    = sq;
            assign res_in[j]  = '0;
            assign side_in[j] = in_side;
        end else begin : g_next
            assign x_in[j]    = x_reg[j-1];
            assign res_in[j]  = res_reg[j-1];
            assign side_in[j] = side_reg[j-1];
        end

        assign trial = {1'b0, res_in[j]} + {1'b0, BITV};

        always_ff @(posedge aclk) begin
            if (adv) begin
                if ({1'b0, x_in[j]} >= trial) begin
                    x_reg[j]   <= x_in[j] - trial[SQW-1:0];
                    res_reg[j] <= (res_in[j] >> 1) + BITV;
                end else begin
                    x_reg[j]   <= x_in[j];
                    res_reg[j] <= res_in[j] >> 1;
                end
                side_reg[j] <= side_in[j];
            end
        end
    end

    // remainder above the root rounds up
    always_ff @(posedge aclk) begin
        if (adv) begin
            len_reg <= LW'(res_reg[SQRT_STEPS-1])
                     + LW'(x_reg[SQRT_STEPS-1] > res_reg[SQRT_STEPS-1]);
            side_out_reg <= side_reg[SQRT_STEPS-1];
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign len       = len_reg;
    assign out_side  = side_out_reg;

endmodule

FILE: design/cdg_grad_div.sv
// ----------------------------------------------------------------------------
// cdg_grad_div
// Pipelined restoring divider for one gradient component:
// round(mag * 2^FRAC_BITS / len), one quotient bit per stage.
// ----------------------------------------------------------------------------
module cdg_grad_div import cdg_pkg::*; (
    input  logic             aclk,
    input  logic             adv,
    input  logic [SW-1:0]    mag,
    input  logic [LW-1:0]    len,
    output logic [QBITS-1:0] quo
);

    localparam int NW = LW + QBITS;

    logic [NW-1:0]    num;
    logic [LW-1:0]    rem_reg [QBITS];
    logic [QBITS-1:0] low_reg [QBITS];
    logic [QBITS-1:0] q_reg [QBITS];
    logic [LW-1:0]    d_reg [QBITS];
    logic [LW-1:0]    rem_in [QBITS];
    logic [QBITS-1:0] low_in [QBITS];
    logic [QBITS-1:0] q_in [QBITS];
    logic [LW-1:0]    d_in [QBITS];

    // numerator stays below len * 2^QBITS, so the top part starts below len
    assign num = (NW'(mag) << FRAC_BITS) + NW'(len >> 1);

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        logic [LW:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign rem_in[j] = num[NW-1:QBITS];
            assign low_in[j] = num[QBITS-1:0];
            assign q_in[j]   = '0;
            assign d_in[j]   = len;
        end else begin : g_next
            assign rem_in[j] = rem_reg[j-1];
            assign low_in[j] = low_reg[j-1];
            assign q_in[j]   = q_reg[j-1];
            assign d_in[j]   = d_reg[j-1];
        end

        assign trial = {rem_in[j], low_in[j][QBITS-1-j]};
        assign ge    = trial >= {1'b0, d_in[j]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j] <= ge ? LW'(trial - {1'b0, d_in[j]}) : trial[LW-1:0];
                low_reg[j] <= low_in[j];
                q_reg[j]   <= q_in[j] | (QBITS'(ge) << (QBITS - 1 - j));
                d_reg[j]   <= d_in[j];
            end
        end
    end

    assign quo = q_reg[QBITS-1];

endmodule

FILE: design/cylinder_distance_gradient.sv
// ----------------------------------------------------------------------------
// cylinder_distance_gradient
// Q16.16 signed distance to an infinite cylinder and its 18-bit unit gradient, 16 fraction bits.
// ----------------------------------------------------------------------------
//   port group | direction | contents
//   cfg_*      | in        | register write: enable, index, 32-bit data
//   s_*        | in        | query point x, y, z (valid / ready)
//   m_*        | out       | distance, gradient x, y, z, on-axis flag
//
// One item per cycle unless m_ready stalls or an axis rebuild runs; 9 projection
// stages, 33 square root stages, 17 divider stages, one output register.
// After a write to an axis register the unit axis is rebuilt by a sequential
// normalizer (shift, square root, three long divisions): s_ready stays low until
// it is done. After reset the +z axis is ready at once.
// m_ready low with m_valid high freezes the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn, synchronous) clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module cylinder_distance_gradient import cdg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CIW-1:0]       cfg_idx,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [DW-1:0] s_point_x,
    input  logic signed [DW-1:0] s_point_y,
    input  logic signed [DW-1:0] s_point_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [DW-1:0] m_signed_distance,
    output logic signed [GW-1:0] m_grad_x,
    output logic signed [GW-1:0] m_grad_y,
    output logic signed [GW-1:0] m_grad_z,
    output logic                 m_on_axis
);

    logic signed [DW-1:0] center_reg [3];
    logic signed [DW-1:0] axis_reg [3];
    logic [30:0]          radius_reg;
    logic                 axis_wr;
    logic                 busy;
    logic                 adv;

    logic signed [DW-1:0] pt [3];
    logic signed [UW-1:0] u [3];

    logic            pj_valid;
    logic [SQW-1:0]  pj_sq;
    sqrt_side_t      pj_side;
    logic            sr_valid;
    logic [LW-1:0]   sr_len;
    sqrt_side_t      sr_side;

    logic [QBITS-1:0] quo [3];
    logic [QBITS-1:0] dl_vld_reg;
    grad_side_t       dl_side_reg [QBITS];
    grad_side_t       dl_entry;

    logic signed [LW+7:0] dext;
    logic [LW+6:0]        lshift;

    logic                 m_valid_reg;
    logic signed [DW-1:0] dist_reg;
    logic signed [GW-1:0] grad_reg [3];
    logic                 on_axis_reg;
    logic signed [GW-1:0] gval [3];
    logic [31:0]          gm;

    assign axis_wr = cfg_we && (cfg_idx == REG_AXIS_X || cfg_idx == REG_AXIS_Y
                                || cfg_idx == REG_AXIS_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= 31'd65536;
            axis_reg[0]   <= '0;
            axis_reg[1]   <= '0;
            axis_reg[2]   <= 32'sd65536;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_RADIUS:   radius_reg    <= cfg_wdata[30:0];
                REG_AXIS_X:   axis_reg[0]   <= cfg_wdata;
                REG_AXIS_Y:   axis_reg[1]   <= cfg_wdata;
                REG_AXIS_Z:   axis_reg[2]   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cdg_axis_norm u_axis (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (axis_wr),
        .axis    (axis_reg),
        .u       (u),
        .busy    (busy)
    );

    // whole pipeline moves together, the output register being its last stage
    assign adv     = m_ready || !m_valid_reg;
    assign s_ready = adv && !busy;

    assign pt[0] = s_point_x;
    assign pt[1] = s_point_y;
    assign pt[2] = s_point_z;

    cdg_project u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid && !busy),
        .p         (pt),
        .c         (center_reg),
        .u         (u),
        .out_valid (pj_valid),
        .sq        (pj_sq),
        .side      (pj_side)
    );

    cdg_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pj_valid),
        .sq        (pj_sq),
        .in_side   (pj_side),
        .out_valid (sr_valid),
        .len       (sr_len),
        .out_side  (sr_side)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        cdg_grad_div u_div (
            .aclk (aclk),
            .adv  (adv),
            .mag  (sr_side.mag[i]),
            .len  (sr_len),
            .quo  (quo[i])
        );
    end

    // distance with saturation, computed alongside the first divider step
    always_comb begin
        lshift = (LW+7)'(sr_len) << sr_side.k;
        dext   = $signed({1'b0, lshift}) - $signed((LW+8)'(radius_reg));
        dl_entry.on_axis = sr_len == '0;
        dl_entry.neg     = sr_side.neg;
        if (dext > $signed((LW+8)'(32'h7fff_ffff)))
            dl_entry.sdist = 32'sh7fff_ffff;
        else if (dext < -$signed((LW+8)'(32'h8000_0000)))
            dl_entry.sdist = 32'sh8000_0000;
        else
            dl_entry.sdist = DW'(dext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) dl_vld_reg <= '0;
        else if (adv) dl_vld_reg <= {dl_vld_reg[QBITS-2:0], sr_valid};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dl_side_reg[0] <= dl_entry;
            for (int j = 1; j < QBITS; j++) dl_side_reg[j] <= dl_side_reg[j-1];
        end
    end

    always_comb begin
        gm = '0;
        for (int i = 0; i < 3; i++) begin
            gm = 32'(quo[i]);
            if (gm > 32'(GRAD_ONE)) gm = 32'(GRAD_ONE);
            if (dl_side_reg[QBITS-1].neg[i]) begin
                if (gm > 32'(GRAD_MAX + 1)) gm = 32'(GRAD_MAX + 1);
                gval[i] = GW'(-$signed({1'b0, gm}));
            end else begin
                if (gm > 32'(GRAD_MAX)) gm = 32'(GRAD_MAX);
                gval[i] = GW'(gm);
            end
            if (dl_side_reg[QBITS-1].on_axis) gval[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= dl_vld_reg[QBITS-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dist_reg    <= dl_side_reg[QBITS-1].sdist;
            on_axis_reg <= dl_side_reg[QBITS-1].on_axis;
            grad_reg    <= gval;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_signed_distance = dist_reg;
    assign m_grad_x          = grad_reg[0];
    assign m_grad_y          = grad_reg[1];
    assign m_grad_z          = grad_reg[2];
    assign m_on_axis         = on_axis_reg;

endmodule

FILE: design/cdg_checker.sv
// ----------------------------------------------------------------------------
// cdg_checker
// Port-level checks for cylinder_distance_gradient, bound to the top level.
// ----------------------------------------------------------------------------
module cdg_checker import cdg_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_we,
    input logic [CIW-1:0]       cfg_idx,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic signed [DW-1:0] m_signed_distance,
    input logic signed [GW-1:0] m_grad_x,
    input logic signed [GW-1:0] m_grad_y,
    input logic signed [GW-1:0] m_grad_z,
    input logic                 m_on_axis
);

    // stalled result holds its distance, x gradient and on-axis flag
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_signed_distance)
                                && $stable(m_grad_x) && $stable(m_on_axis))
        else $error("result changed while stalled");

    // on-axis items carry a zero gradient
    a_on_axis_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_on_axis |-> m_grad_x == '0 && m_grad_y == '0 && m_grad_z == '0)
        else $error("nonzero gradient on axis");

    // gradient components never exceed unit length
    a_grad_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_grad_x) <= GRAD_ONE && $signed(m_grad_x) >= -GRAD_ONE
                 && $signed(m_grad_y) <= GRAD_ONE && $signed(m_grad_y) >= -GRAD_ONE
                 && $signed(m_grad_z) <= GRAD_ONE && $signed(m_grad_z) >= -GRAD_ONE)
        else $error("gradient out of range");

    // an axis write stops intake while the axis is rebuilt
    a_axis_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_idx == REG_AXIS_X || cfg_idx == REG_AXIS_Y
                   || cfg_idx == REG_AXIS_Z) |=> !s_ready)
        else $error("item taken during axis rebuild");

    // pipeline is empty out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind cylinder_distance_gradient cdg_checker u_cdg_checker (.*);
